FILE: sv/pft_pkg.sv
// Shared types, constants and CORDIC helpers for the pose frame transform.
package pft_pkg;

  localparam int POS_BITS     = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_STGS  = CORDIC_STEPS / 2;
  localparam int TURN_BITS    = 32;

  localparam logic [1:0] CMD_TO_REF   = 2'd0;
  localparam logic [1:0] CMD_TO_WORLD = 2'd1;
  localparam logic [1:0] CMD_WALK     = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

  typedef struct packed {
    logic signed [POS_BITS:0]   px;
    logic signed [POS_BITS:0]   py;
    logic signed [POS_BITS-1:0] bx;
    logic signed [POS_BITS-1:0] by;
    logic [ANGLE_BITS-1:0]      oh;
    logic                       kill;
    logic                       to_ref;
    logic                       flip;
  } car_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } rot_t;

  function automatic logic signed [32:0] atan_turn(input int i);
    logic signed [32:0] a;
    case (i)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      20: a = 33'sd652;
      21: a = 33'sd326;
      22: a = 33'sd163;
      23: a = 33'sd81;
      24: a = 33'sd41;
      25: a = 33'sd20;
      26: a = 33'sd10;
      27: a = 33'sd5;
      28: a = 33'sd3;
      29: a = 33'sd1;
      default: a = 33'sd0;
    endcase
    return a;
  endfunction

  // one micro-rotation, shifts floor toward minus infinity
  function automatic rot_t cordic_step(input rot_t r, input int i);
    rot_t o;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (r.z >= 0) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan_turn(i);
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan_turn(i);
    end
    return o;
  endfunction

endpackage

FILE: sv/pose_frame_transform.sv
// Pose frame transform: pipelined CORDIC rotation with saturating Q16.16 output.
//
// Input beat: cmd, reference pose (base_x/y, base_heading) and item pose
// (item_x/y, item_heading). cmd 0 maps the item into the reference frame,
// cmd 1 out to the world frame, cmd 2 composes the two poses; cmd 3 gives
// an all-zero result. Positions are signed Q16.16 and saturate, with
// out_saturated flagging a clip. Headings are binary angles and wrap.
// Both channels are valid/ready; one result beat per input beat, in order.
// There are 20 register stages: one input stage, 15 CORDIC stages of two
// micro-rotations each, three multiply stages (magnitudes, 17x33 partial
// products, rounding) and the add/clip stage, which is the output register.
// Throughput is one beat per cycle; the pipeline advances as a whole and
// freezes while a finished beat waits in the output register.
// Reset (rst_n low, synchronous) empties the pipeline; payload registers keep
// their state, which does not matter. A receiver stall holds every stage, nothing is
// dropped or repeated.
module pose_frame_transform (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic signed [pft_pkg::POS_BITS-1:0] in_base_x,
  input  logic signed [pft_pkg::POS_BITS-1:0] in_base_y,
  input  logic signed [pft_pkg::ANGLE_BITS-1:0] in_base_heading,
  input  logic signed [pft_pkg::POS_BITS-1:0] in_item_x,
  input  logic signed [pft_pkg::POS_BITS-1:0] in_item_y,
  input  logic signed [pft_pkg::ANGLE_BITS-1:0] in_item_heading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pft_pkg::POS_BITS-1:0] out_x,
  output logic signed [pft_pkg::POS_BITS-1:0] out_y,
  output logic signed [pft_pkg::ANGLE_BITS-1:0] out_heading,
  output logic                                out_saturated
);
  import pft_pkg::*;

  localparam int NSTG   = CORDIC_STGS + 5;
  localparam int S_MAG  = CORDIC_STGS + 1;
  localparam int S_PART = CORDIC_STGS + 2;
  localparam int S_RND  = CORDIC_STGS + 3;
  localparam int SW     = POS_BITS + 10;
  localparam logic signed [SW-1:0] POS_MAX = SW'((64'sd1 <<< (POS_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);

  logic [NSTG-1:0] vld_r;
  logic            en;
  car_t            car_r [0:S_RND];
  rot_t            rot_r [0:CORDIC_STGS];

  assign en        = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // input stage: operands, rotation angle and quadrant fold
  car_t car_nxt;
  rot_t rot_nxt;
  always_comb begin
    logic [ANGLE_BITS-1:0] rot;
    logic signed [32:0]    z;
    car_nxt.to_ref = (in_cmd == CMD_TO_REF);
    car_nxt.kill   = (in_cmd == CMD_NONE);
    car_nxt.bx     = in_base_x;
    car_nxt.by     = in_base_y;
    if (car_nxt.to_ref) begin
      car_nxt.px = (POS_BITS+1)'(in_item_x) - (POS_BITS+1)'(in_base_x);
      car_nxt.py = (POS_BITS+1)'(in_item_y) - (POS_BITS+1)'(in_base_y);
      rot        = ANGLE_BITS'(0) - in_base_heading;
    end else begin
      car_nxt.px = (POS_BITS+1)'(in_item_x);
      car_nxt.py = (POS_BITS+1)'(in_item_y);
      if (in_cmd == CMD_WALK) rot = in_base_heading + in_item_heading;
      else                    rot = in_base_heading;
    end
    car_nxt.oh = (in_cmd == CMD_WALK) ? rot : in_item_heading;
    z = 33'(signed'({rot, {(TURN_BITS-ANGLE_BITS){1'b0}}}));
    car_nxt.flip = 1'b0;
    if (z > QUARTER_TURN) begin
      z = z - HALF_TURN;
      car_nxt.flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
      car_nxt.flip = 1'b1;
    end
    rot_nxt.x = CORDIC_GAIN;
    rot_nxt.y = '0;
    rot_nxt.z = z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0] <= car_nxt;
      rot_r[0] <= rot_nxt;
    end
  end

  for (genvar k = 1; k <= CORDIC_STGS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        car_r[k] <= car_r[k-1];
        rot_r[k] <= cordic_step(cordic_step(rot_r[k-1], 2*k-2), 2*k-1);
      end
    end
  end

  // magnitudes and product signs
  logic [POS_BITS:0] am_x_r, am_y_r;
  logic [32:0]       cm_r, sm_r;
  logic [3:0]        neg_r;   // px*c, py*s, px*s, py*c
  always_ff @(posedge clk) begin
    logic signed [33:0] c, s;
    logic               pxn, pyn;
    if (en) begin
      c = car_r[CORDIC_STGS].flip ? -rot_r[CORDIC_STGS].x : rot_r[CORDIC_STGS].x;
      s = car_r[CORDIC_STGS].flip ? -rot_r[CORDIC_STGS].y : rot_r[CORDIC_STGS].y;
      pxn = car_r[CORDIC_STGS].px[POS_BITS];
      pyn = car_r[CORDIC_STGS].py[POS_BITS];
      am_x_r <= pxn ? -car_r[CORDIC_STGS].px : car_r[CORDIC_STGS].px;
      am_y_r <= pyn ? -car_r[CORDIC_STGS].py : car_r[CORDIC_STGS].py;
      cm_r   <= 33'(c[33] ? -c : c);
      sm_r   <= 33'(s[33] ? -s : s);
      neg_r  <= {pyn ^ c[33], pxn ^ s[33], pyn ^ s[33], pxn ^ c[33]};
      car_r[S_MAG] <= car_r[CORDIC_STGS];
    end
  end

  // partial products, high and low halves of the position magnitude
  localparam int LB = 16;
  localparam int HB = POS_BITS + 1 - LB;
  logic [HB+32:0] ph_r [0:3];
  logic [LB+32:0] pl_r [0:3];
  logic [3:0]     neg2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      ph_r[0] <= am_x_r[POS_BITS:LB] * cm_r;
      pl_r[0] <= am_x_r[LB-1:0] * cm_r;
      ph_r[1] <= am_y_r[POS_BITS:LB] * sm_r;
      pl_r[1] <= am_y_r[LB-1:0] * sm_r;
      ph_r[2] <= am_x_r[POS_BITS:LB] * sm_r;
      pl_r[2] <= am_x_r[LB-1:0] * sm_r;
      ph_r[3] <= am_y_r[POS_BITS:LB] * cm_r;
      pl_r[3] <= am_y_r[LB-1:0] * cm_r;
      neg2_r  <= neg_r;
      car_r[S_PART] <= car_r[S_MAG];
    end
  end

  // round half away from zero at 2^-30, reapply sign
  localparam int FW = HB + 33 + LB + 1;
  logic signed [SW-1:0] prd_r [0:3];
  for (genvar p = 0; p < 4; p++) begin : g_rnd
    logic [FW-1:0] full;
    logic [SW-1:0] mag;
    assign full = ({(FW-HB-33)'(0), ph_r[p]} << LB) + FW'(pl_r[p])
                + (FW'(1) << 29);
    assign mag  = SW'(full >> 30);
    always_ff @(posedge clk) begin
      if (en) prd_r[p] <= neg2_r[p] ? -signed'(mag) : signed'(mag);
    end
  end
  always_ff @(posedge clk) begin
    if (en) car_r[S_RND] <= car_r[S_PART];
  end

  // sums, clip and output register
  always_ff @(posedge clk) begin
    logic signed [SW-1:0] ox, oy;
    logic                 hit;
    if (en) begin
      ox = prd_r[0] - prd_r[1];
      oy = prd_r[2] + prd_r[3];
      if (!car_r[S_RND].to_ref) begin
        ox = ox + SW'(car_r[S_RND].bx);
        oy = oy + SW'(car_r[S_RND].by);
      end
      hit = 1'b0;
      if (ox > POS_MAX) begin ox = POS_MAX; hit = 1'b1; end
      else if (ox < POS_MIN) begin ox = POS_MIN; hit = 1'b1; end
      if (oy > POS_MAX) begin oy = POS_MAX; hit = 1'b1; end
      else if (oy < POS_MIN) begin oy = POS_MIN; hit = 1'b1; end
      if (car_r[S_RND].kill) begin
        out_x         <= '0;
        out_y         <= '0;
        out_heading   <= '0;
        out_saturated <= 1'b0;
      end else begin
        out_x         <= ox[POS_BITS-1:0];
        out_y         <= oy[POS_BITS-1:0];
        out_heading   <= car_r[S_RND].oh;
        out_saturated <= hit;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == POS_BITS'(POS_MAX) || out_x == POS_BITS'(POS_MIN) ||
      out_y == POS_BITS'(POS_MAX) || out_y == POS_BITS'(POS_MIN))
    else $error("saturated flag without a clipped position");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during a stall");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat not in first stage");
`endif

endmodule

FILE: tb/tb_pose_frame_transform.sv
// Self-checking testbench for pose_frame_transform: directed table, random poses, stalls.
`timescale 1ns / 1ps

module tb_pose_frame_transform;
  import pft_pkg::*;

  localparam int  N_RANDOM  = 950;
  localparam int  LATENCY   = 20;
  localparam int  MAX_CYC   = 600000;
  localparam longint HALF_T = 64'sd2147483648;
  localparam longint QUAR_T = 64'sd1073741824;
  localparam longint POS_HI = 64'sd2147483647;
  localparam longint POS_LO = -64'sd2147483648;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [15:0] bh;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [15:0] ih;
    bit                 typed;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [15:0] eh;
    logic               esat;
  } pose_beat_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] h;
    logic               sat;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = CMD_NONE;
  logic signed [31:0] in_base_x = '0, in_base_y = '0, in_item_x = '0, in_item_y = '0;
  logic signed [15:0] in_base_heading = '0, in_item_heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y;
  logic signed [15:0] out_heading;
  logic out_saturated;

  pose_beat_t  dir_rows[$];
  pose_beat_t  sent_rows[$];
  pose_res_t   pending_poses[$];
  int          n_accepted = 0, n_results = 0, n_errors = 0, n_sat = 0, cyc = 0;
  int          n_to_send = 0;
  bit          calm = 1'b0;
  bit          long_hold_req = 1'b0;

  pose_frame_transform u_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("timeout after %0d cycles, %0d beats still due", cyc, pending_poses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // CORDIC arctangent steps in 2^-32 turns
  localparam longint ATAN_T [30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  function automatic void angle_trig(input logic [15:0] ang, output longint c,
                                     output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({ang, 16'h0000});
    if (z >= HALF_T) z = z - 2 * HALF_T;
    flip = 1'b0;
    x = 64'sd652032874;
    y = '0;
    if (z > QUAR_T) begin
      z -= HALF_T;
      flip = 1'b1;
    end else if (z < -QUAR_T) begin
      z += HALF_T;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_T[i];
      end else begin
        x += dx; y -= dy; z += ATAN_T[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // product scaled by 2^-30, rounded half away from zero
  function automatic longint scale_q30(input longint a, input longint c);
    longint unsigned am, cm, r;
    bit neg;
    neg = (a < 0) != (c < 0);
    am = (a < 0) ? -a : a;
    cm = (c < 0) ? -c : c;
    r = (am >> 30) * cm + (((am & 64'h3fff_ffff) * cm + (64'd1 << 29)) >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip_pos(input longint v, inout logic hit);
    if (v > POS_HI) begin
      hit = 1'b1;
      return POS_HI;
    end
    if (v < POS_LO) begin
      hit = 1'b1;
      return POS_LO;
    end
    return v;
  endfunction

  function automatic pose_res_t transform_pose(input pose_beat_t b);
    pose_res_t r;
    longint px, py, ox, oy, c, s;
    logic [15:0] rot;
    logic hit;
    r = '{default: '0};
    if (b.cmd == CMD_NONE) return r;
    hit = 1'b0;
    if (b.cmd == CMD_TO_REF) begin
      px = longint'(b.ix) - longint'(b.bx);
      py = longint'(b.iy) - longint'(b.by);
      rot = 16'(-b.bh);
      r.h = b.ih;
    end else begin
      px = longint'(b.ix);
      py = longint'(b.iy);
      rot = (b.cmd == CMD_TO_WORLD) ? b.bh : 16'(b.bh + b.ih);
      r.h = (b.cmd == CMD_TO_WORLD) ? b.ih : rot;
    end
    angle_trig(rot, c, s);
    ox = scale_q30(px, c) - scale_q30(py, s);
    oy = scale_q30(px, s) + scale_q30(py, c);
    if (b.cmd != CMD_TO_REF) begin
      ox += longint'(b.bx);
      oy += longint'(b.by);
    end
    r.x = 32'(clip_pos(ox, hit));
    r.y = 32'(clip_pos(oy, hit));
    r.sat = hit;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    n_errors++;
    $display("[%0d] beat %0d %s: got %0d want %0d", cyc, n_results, field, got, want);
  endtask

  function automatic logic signed [31:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return 32'($urandom_range(0, 2000)) - 1000;
      4, 5: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh4000;
      3: return 16'shc000;
      4: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pose_beat_t row(input logic [1:0] cmd, input logic signed [31:0] bx,
      by, input logic signed [15:0] bh, input logic signed [31:0] ix, iy,
      input logic signed [15:0] ih);
    pose_beat_t b;
    b = '{cmd: cmd, bx: bx, by: by, bh: bh, ix: ix, iy: iy, ih: ih, default: '0};
    return b;
  endfunction

  // accepted input beats: predict and queue
  always @(posedge clk) begin
    pose_beat_t b;
    if (rst_n && in_valid && in_ready) begin
      b = row(in_cmd, in_base_x, in_base_y, in_base_heading, in_item_x, in_item_y,
              in_item_heading);
      if (sent_rows.size() != 0 && sent_rows[0].typed) begin
        pending_poses.push_back('{sent_rows[0].ex, sent_rows[0].ey, sent_rows[0].eh,
                                  sent_rows[0].esat});
      end else begin
        pending_poses.push_back(transform_pose(b));
      end
      if (sent_rows.size() != 0) void'(sent_rows.pop_front());
      n_accepted++;
    end
  end

  // result beats against the oldest prediction
  always @(posedge clk) begin
    pose_res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected beat, x", longint'(out_x), 64'sd0);
      end else begin
        w = pending_poses.pop_front();
        if (out_x !== w.x) report_mismatch("x", longint'(out_x), longint'(w.x));
        if (out_y !== w.y) report_mismatch("y", longint'(out_y), longint'(w.y));
        if (out_heading !== w.h)
          report_mismatch("heading", longint'(out_heading), longint'(w.h));
        if (out_saturated !== w.sat)
          report_mismatch("saturated", longint'(out_saturated), longint'(w.sat));
        if (w.sat) n_sat++;
      end
      n_results++;
    end
  end

  // receiver
  initial begin
    int n;
    bit held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      n = calm ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(input pose_beat_t b);
    int n;
    n = calm ? 0 : $urandom_range(0, 17);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    sent_rows.push_back(b);
    in_valid <= 1'b1;
    in_cmd <= b.cmd;
    in_base_x <= b.bx;
    in_base_y <= b.by;
    in_base_heading <= b.bh;
    in_item_x <= b.ix;
    in_item_y <= b.iy;
    in_item_heading <= b.ih;
    do @(posedge clk); while (!in_ready);
    n_to_send--;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_poses.size() != 0 || sent_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    pose_beat_t b;
    // unused command gives an all-zero result whatever the payload
    b = row(CMD_NONE, 32'sh7fff_ffff, 32'sh8000_0000, 16'sh7fff, 32'sh8000_0000,
            32'sh7fff_ffff, 16'sh8000);
    b.typed = 1'b1;
    dir_rows.push_back(b);
    b = row(CMD_NONE, -32'sd1, -32'sd1, -16'sd1, -32'sd1, -32'sd1, -16'sd1);
    b.typed = 1'b1;
    dir_rows.push_back(b);
    for (int c = CMD_TO_REF; c <= CMD_WALK; c++) begin
      dir_rows.push_back(row(2'(c), '0, '0, '0, 32'sh0001_0000, 32'sh0002_0000,
                             16'sh1234));
      dir_rows.push_back(row(2'(c), 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh8000,
                             32'sh8000_0000, 32'sh8000_0000, 16'sh8000));
      dir_rows.push_back(row(2'(c), 32'sh8000_0000, 32'sh8000_0000, 16'sh7fff,
                             32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff));
      dir_rows.push_back(row(2'(c), 32'sh0010_0000, -32'sh0030_0000, 16'sh4000,
                             32'sh0005_8000, 32'sh0001_0000, 16'shc000));
      // heading sum overflow, and negated minus pi
      dir_rows.push_back(row(2'(c), 32'sh7fff_0000, 32'sh0, 16'sh7000, 32'sh7fff_0000,
                             -32'sh7fff_0000, 16'sh7000));
      dir_rows.push_back(row(2'(c), -32'sd1, 32'sd1, 16'sh8000, 32'sd1, -32'sd1,
                             16'sh0));
      dir_rows.push_back(row(2'(c), 32'sh5555_5555, 32'shaaaa_aaaa, 16'sh5555,
                             32'shaaaa_aaaa, 32'sh5555_5555, 16'shaaaa));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    n_to_send = dir_rows.size() + N_RANDOM;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);
    drain_all();   // sender waits for every result

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 120 == 0) calm = ($urandom_range(0, 2) == 0);
      if (i == 200) begin
        calm = 1'b1;
        long_hold_req = 1'b1;  // receiver stops while beats keep coming
      end
      if (i == 260) calm = 1'b0;
      if (i == 500) drain_all();
      b = row(($urandom_range(0, 15) == 0) ? CMD_NONE : 2'($urandom_range(0, 2)),
              pick_pos(), pick_pos(), pick_angle(), pick_pos(), pick_pos(), pick_angle());
      send_beat(b);
    end
    in_valid <= 1'b0;
    while (pending_poses.size() != 0 || sent_rows.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("%0d beats in, %0d results checked, %0d of them saturated", n_accepted,
             n_results, n_sat);
    $display("covered every command, extreme positions and headings, stalls on both sides");
    if (n_errors == 0 && pending_poses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
